// ===== hdl/itra_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// itra_pkg
// Types, constants and helpers for the integer to radix ASCII converter.
// ---------------------------------------------------------------------------
package itra_pkg;

   localparam int NUM_W      = 32;
   localparam int MAG_W      = NUM_W + 1;
   localparam int MAX_DIGITS = 32;
   localparam int DIG_W      = 4;
   localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
   localparam int ADDR_W     = $clog2(MAX_DIGITS);
   localparam int STEP_BITS  = 8;
   localparam int CHUNKS     = (MAG_W + STEP_BITS - 1) / STEP_BITS;
   localparam int DIV_W      = CHUNKS * STEP_BITS;
   localparam int CHUNK_W    = $clog2(CHUNKS);
   localparam int RADIX_W    = 5;
   localparam int CHAR_W     = 8;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
   localparam logic [RADIX_W-1:0] RADIX_DEC   = 5'd10;

   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
   localparam logic [DIG_W-1:0]  DIG_TEN    = 4'd10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SIGN,
      ST_FETCH,
      ST_LOAD
   } itra_state_type;

   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIG_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d < DIG_TEN) begin
         c = CHAR_ZERO + CHAR_W'(d);
      end else begin
         c = CHAR_A + CHAR_W'(d - DIG_TEN);
      end
      return c;
   endfunction

endpackage : itra_pkg
`default_nettype wire

// ===== hdl/itra_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// itra_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module itra_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule : itra_ram
`default_nettype wire

// ===== hdl/integer_to_radix_ascii.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// integer_to_radix_ascii
// Signed 32-bit integer to ASCII text in a radix of 2 to 16, one character
// per output transaction, most significant digit first.
// ---------------------------------------------------------------------------
// One number is converted at a time. After acceptance the magnitude is
// divided by the radix in a radix divider that retires 8 dividend bits
// per cycle; the digits go to a 32-entry store. Characters are then read
// back through a fetch state and a load state and handed to the output
// register, after a leading minus (radix 10 only) from a sign state;
// output stalls hold the sign and load states. Radix values outside
// 2..16 saturate; at most the 32 least significant digits are emitted.
// The input is not taken while a conversion is under way, but a new
// number may be accepted while the final character waits on the output.
// ---------------------------------------------------------------------------
module integer_to_radix_ascii
   import itra_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_wr_en,
   input  wire logic [RADIX_W-1:0]       csr_wr_data,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic signed [NUM_W-1:0]  req_number_in,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic      [CHAR_W-1:0]        rsp_char_out,
   output logic                          rsp_last_char
);

   itra_state_type        state_ff, state_in;
   logic [RADIX_W-1:0]    radix_ff;
   logic [RADIX_W-1:0]    rad_ff, rad_in;
   logic [DIV_W-1:0]      div_ff, div_in;
   logic [RADIX_W-1:0]    rem_ff, rem_in;
   logic [CHUNK_W-1:0]    chunk_ff, chunk_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  sign_ff, sign_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]     rsp_char_ff, rsp_char_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  accept;
   logic                  out_free;
   logic                  digit_done;
   logic                  div_last;
   logic [RADIX_W-1:0]    rad_eff;
   logic [MAG_W-1:0]      mag;
   logic [STEP_BITS-1:0]  qbyte;
   logic [RADIX_W-1:0]    rem_step;
   logic [RADIX_W-1:0]    trial;
   logic [DIV_W-1:0]      quot;
   logic [DIG_W-1:0]      rd_digit;
   logic [ADDR_W-1:0]     rd_addr;

   assign accept     = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_out  = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;
   assign rd_addr    = ADDR_W'(cnt_ff - 1'b1);
   assign div_last   = (chunk_ff == CHUNK_W'(CHUNKS - 1));

   // saturate the radix register
   always_comb begin
      if (radix_ff inside {[RADIX_MIN:RADIX_MAX]}) begin
         rad_eff = radix_ff;
      end else if (radix_ff < RADIX_MIN) begin
         rad_eff = RADIX_MIN;
      end else begin
         rad_eff = RADIX_MAX;
      end
   end

   always_comb begin
      if (req_number_in[NUM_W-1]) begin
         mag = {1'b1, {NUM_W{1'b0}}} - {1'b0, req_number_in};
      end else begin
         mag = {1'b0, req_number_in};
      end
   end

   // radix divider: eight restoring steps per cycle
   always_comb begin
      rem_step = rem_ff;
      qbyte    = '0;
      trial    = '0;
      for (int i = STEP_BITS - 1; i >= 0; i--) begin
         trial = {rem_step[RADIX_W-2:0], div_ff[DIV_W-STEP_BITS+i]};
         if (trial >= rad_ff) begin
            rem_step = trial - rad_ff;
            qbyte[i] = 1'b1;
         end else begin
            rem_step = trial;
         end
      end
      quot = {div_ff[DIV_W-STEP_BITS-1:0], qbyte};
   end

   assign digit_done = (state_ff == ST_DIVIDE) && div_last &&
                       ((quot == '0) || (cnt_ff == CNT_W'(MAX_DIGITS - 1)));

   itra_ram #(
      .WIDTH (DIG_W),
      .DEPTH (MAX_DIGITS)
   ) u_digits (
      .clock   (clock),
      .wr_en   ((state_ff == ST_DIVIDE) && div_last),
      .wr_addr (cnt_ff[ADDR_W-1:0]),
      .wr_data (rem_step[DIG_W-1:0]),
      .rd_addr (rd_addr),
      .rd_data (rd_digit)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (digit_done) begin
               state_in = sign_ff ? ST_SIGN : ST_FETCH;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (out_free) begin
               state_in = (cnt_ff == CNT_W'(1)) ? ST_IDLE : ST_FETCH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      rad_in       = rad_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      chunk_in     = chunk_ff;
      cnt_in       = cnt_ff;
      sign_in      = sign_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rad_in   = rad_eff;
               div_in   = DIV_W'(mag);
               rem_in   = '0;
               chunk_in = '0;
               cnt_in   = '0;
               sign_in  = req_number_in[NUM_W-1] && (rad_eff == RADIX_DEC);
            end
         end
         ST_DIVIDE: begin
            div_in = quot;
            if (div_last) begin
               rem_in   = '0;
               chunk_in = '0;
               cnt_in   = cnt_ff + 1'b1;
            end else begin
               rem_in   = rem_step;
               chunk_in = chunk_ff + 1'b1;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_MINUS;
               rsp_last_in  = 1'b0;
               sign_in      = 1'b0;
            end
         end
         ST_FETCH: begin
         end
         ST_LOAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = digit_to_ascii(rd_digit);
               rsp_last_in  = (cnt_ff == CNT_W'(1));
               cnt_in       = cnt_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radix_ff     <= RADIX_RESET;
         rsp_valid_ff <= 1'b0;
         sign_ff      <= 1'b0;
         cnt_ff       <= '0;
         chunk_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sign_ff      <= sign_in;
         cnt_ff       <= cnt_in;
         chunk_ff     <= chunk_in;
         if (csr_wr_en) begin
            radix_ff <= csr_wr_data;
         end
      end
      rad_ff      <= rad_in;
      div_ff      <= div_in;
      rem_ff      <= rem_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule : integer_to_radix_ascii
`default_nettype wire

// ===== tb/sv/itra_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// itra_checker
// Watches the number and character channels of the radix ASCII converter,
// works out the expected text of every accepted number and compares each
// character transaction against it in order.
// ---------------------------------------------------------------------------
module itra_checker
   import itra_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [RADIX_W-1:0]       csr_wr_data,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic signed [NUM_W-1:0]  req_number_in,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [CHAR_W-1:0]        rsp_char_out,
   input  logic                     rsp_last_char,
   output int                       fail_count,
   output int                       outstanding
);

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } text_char_t;

   text_char_t         expected_text[$];
   logic [RADIX_W-1:0] radix_setting;

   initial begin
      fail_count    = 0;
      outstanding   = 0;
      radix_setting = RADIX_RESET;
   end

   task automatic report_mismatch(input string what);
      $display("%0t ns checker: %s", $realtime, what);
      fail_count++;
   endtask

   function automatic void convert_number(input logic [NUM_W-1:0] number,
                                          input logic [RADIX_W-1:0] setting);
      logic [MAG_W-1:0]   mag;
      logic [MAG_W-1:0]   base;
      logic [DIG_W-1:0]   digits [MAX_DIGITS];
      logic [DIG_W-1:0]   d;
      logic [CHAR_W-1:0]  c;
      logic               with_sign;
      int                 count;
      int                 n;
      if (setting < RADIX_MIN) begin
         base = MAG_W'(RADIX_MIN);
      end else if (setting > RADIX_MAX) begin
         base = MAG_W'(RADIX_MAX);
      end else begin
         base = MAG_W'(setting);
      end
      mag = number[NUM_W-1] ? (33'h1_0000_0000 - {1'b0, number}) : {1'b0, number};
      with_sign = number[NUM_W-1] && (base == MAG_W'(RADIX_DEC));
      count = 0;
      do begin
         digits[count] = DIG_W'(mag % base);
         mag = mag / base;
         count++;
      end while (mag != 0 && count < MAX_DIGITS);
      n = 0;
      if (with_sign) begin
         expected_text.push_back('{ch: CHAR_MINUS, last: 1'b0});
         n++;
      end
      for (int k = count; k > 0 && n < MAX_DIGITS; k--) begin
         d = digits[k-1];
         c = (d < 4'd10) ? CHAR_ZERO + CHAR_W'(d) : CHAR_A + CHAR_W'(d - 4'd10);
         expected_text.push_back('{ch: c, last: (k == 1 || n == MAX_DIGITS - 1)});
         n++;
      end
   endfunction

   always @(posedge clock) begin
      text_char_t want;
      if (reset) begin
         expected_text.delete();
         radix_setting = RADIX_RESET;
      end else begin
         if (csr_wr_en) begin
            radix_setting = csr_wr_data;
         end
         if (req_valid && !req_stall) begin
            convert_number(req_number_in, radix_setting);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_text.size() == 0) begin
               report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                         rsp_char_out, rsp_last_char));
            end else begin
               want = expected_text.pop_front();
               if (rsp_char_out !== want.ch) begin
                  report_mismatch($sformatf("char_out 0x%02h, wanted 0x%02h",
                                            rsp_char_out, want.ch));
               end
               if (rsp_last_char !== want.last) begin
                  report_mismatch($sformatf("last_char %0b, wanted %0b on 0x%02h",
                                            rsp_last_char, want.last, want.ch));
               end
            end
         end
      end
      outstanding = expected_text.size();
   end

endmodule : itra_checker

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Regression for the integer to radix ASCII converter.
// Drives directed and random numbers under changing radix settings and
// idling patterns, with a long output hold-off; the checker does the
// comparison and this top gives the verdict.
// ---------------------------------------------------------------------------
module tb;
   import itra_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int LONG_HOLD    = 300;
   localparam int SETTLE       = 8;
   localparam int TAIL         = 250;
   localparam int BLOCK_ITEMS  = 29;

   logic                    clock;
   logic                    reset;
   logic                    csr_wr_en;
   logic [RADIX_W-1:0]      csr_wr_data;
   logic                    req_valid;
   logic                    req_stall;
   logic signed [NUM_W-1:0] req_number_in;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [CHAR_W-1:0]       rsp_char_out;
   logic                    rsp_last_char;

   int   fail_count;
   int   outstanding;
   int   cycle_count  = 0;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   logic hold_trigger = 1'b0;
   logic hold_seen    = 1'b0;
   int   hold_left    = 0;

   integer_to_radix_ascii DUT (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_number_in (req_number_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_out  (rsp_char_out),
      .rsp_last_char (rsp_last_char)
   );

   itra_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_number_in (req_number_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_out  (rsp_char_out),
      .rsp_last_char (rsp_last_char),
      .fail_count    (fail_count),
      .outstanding   (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // character side: random stall, or a long hold-off when triggered
   always @(posedge clock) begin
      if (hold_trigger != hold_seen) begin
         hold_seen <= hold_trigger;
         hold_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic send_number(input logic [NUM_W-1:0] value);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid     <= 1'b1;
      req_number_in <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // hold input until every expected character has arrived
   task automatic drain_text();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_radix(input logic [RADIX_W-1:0] value);
      drain_text();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [NUM_W-1:0] pick_number();
      logic [NUM_W-1:0] v;
      case ($urandom_range(9))
         4: v = $urandom_range(0, 40);
         5: v = -$urandom_range(1, 40);
         6: begin
            case ($urandom_range(4))
               0: v = 32'h8000_0000;
               1: v = 32'h7FFF_FFFF;
               2: v = 32'hFFFF_FFFF;
               3: v = 32'h0000_0001;
               default: v = 32'h0000_0000;
            endcase
         end
         7: v = $urandom >> $urandom_range(31);
         8: v = -($urandom >> $urandom_range(31));
         default: v = $urandom;
      endcase
      return v;
   endfunction

   initial begin
      logic [RADIX_W-1:0] r;
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      req_valid     = 1'b0;
      req_number_in = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 30;
      recv_idle_pct = 52;

      // reset radix is decimal
      send_number(32'd0);
      send_number(32'd1);
      send_number(-32'sd1);
      send_number(32'd9);
      send_number(32'd10);
      send_number(-32'sd10);
      send_number(32'h7FFF_FFFF);
      send_number(32'h8000_0000);
      send_number(32'd123456789);
      write_radix(5'd16);
      send_number(32'h8000_0000);
      send_number(32'hFFFF_FFFF);
      send_number(32'h00AB_CDEF);
      send_number(32'h7FFF_FFFF);
      write_radix(RADIX_MIN);
      send_number(32'h8000_0000);
      send_number(32'd0);
      send_number(32'h7FFF_FFFF);
      // out-of-range settings saturate, then radix 3 and radix 9
      write_radix(5'd0);
      send_number(32'd5);
      write_radix(5'd1);
      send_number(32'd3);
      write_radix(5'd17);
      send_number(32'd255);
      write_radix(5'd31);
      send_number(32'hFFFF_FFFF);
      write_radix(5'd3);
      send_number(32'h8000_0000);
      write_radix(5'd9);
      send_number(-32'sd5);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 30; recv_idle_pct = 52; end
            1: begin send_idle_pct = 52; recv_idle_pct = 30; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int blk = 0; blk < 3; blk++) begin
            if (blk == 0) begin
               r = RADIX_MAX;
            end else if (blk == 1 && phase != 1) begin
               r = RADIX_DEC;
            end else if ($urandom_range(4) == 0) begin
               r = RADIX_W'($urandom_range(0, 31));
            end else begin
               r = RADIX_W'($urandom_range(2, 16));
            end
            write_radix(r);
            if (phase == 2 && blk == 1) begin
               hold_trigger <= ~hold_trigger;
            end
            for (int i = 0; i < BLOCK_ITEMS; i++) begin
               send_number(pick_number());
            end
         end
      end

      drain_text();
      repeat (TAIL) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule : tb

// ===== sim.f =====
hdl/itra_pkg.sv
hdl/itra_ram.sv
hdl/integer_to_radix_ascii.sv
tb/sv/itra_checker.sv
tb/sv/tb.sv
